// ===== sv/hee_pkg.sv =====
// Shared types and constants for the hex escape unescaper.
package hee_pkg;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] HEX_NONE  = 2'd0;
    localparam logic [1:0] HEX_FIRST = 2'd1;
    localparam logic [1:0] HEX_HELD  = 2'd2;

    localparam logic [7:0]  CHR_BSLASH  = 8'h5c;
    localparam logic [7:0]  CHR_X       = 8'h78;
    localparam logic [7:0]  CASE_BIT    = 8'h20;
    localparam logic [15:0] MAX_RESET   = 16'hffff;
    localparam int          RES_PER_ITEM = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  kind;
        logic [15:0] byte_count;
        logic        run_last;
    } t_out;

    // all results of one item; n counts the used entries (1..3)
    typedef struct packed {
        logic [1:0]                   n;
        t_out [RES_PER_ITEM-1:0]      res;
    } t_bundle;

endpackage

// ===== sv/hee_front.sv =====
// Front end: decodes each item against the escape state and builds its results.
module hee_front import hee_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    input  logic        i_q_full,
    output logic        o_push,
    output t_bundle     o_bundle
);

    typedef struct packed {
        t_bundle     b;
        logic [15:0] cnt;
    } t_acc;

    logic        r_bp, n_bp;
    logic [1:0]  r_hp, n_hp;
    logic [3:0]  r_hn, n_hn;
    logic [15:0] r_cnt, n_cnt;
    logic        r_halt, n_halt;
    logic [15:0] r_max;
    t_acc        acc;
    logic        accept;

    function automatic t_acc f_put(t_acc a, logic [7:0] b, logic [1:0] k);
        t_acc r;
        r = a;
        r.b.res[a.b.n].out_byte   = b;
        r.b.res[a.b.n].kind       = k;
        r.b.res[a.b.n].byte_count = a.cnt;
        r.b.res[a.b.n].run_last   = 1'b0;
        r.b.n                     = a.b.n + 2'd1;
        return r;
    endfunction

    function automatic t_acc f_emit(t_acc a, logic [7:0] b, logic [15:0] mx);
        t_acc r;
        r = a;
        if (a.cnt < mx) begin
            r.cnt = a.cnt + 16'd1;
            r = f_put(r, b, KIND_BYTE);
        end
        return r;
    endfunction

    // {is hex digit, value}
    function automatic logic [4:0] f_hex(logic [7:0] c);
        logic [7:0] l;
        logic [7:0] d;
        l = c | CASE_BIT;
        d = c - 8'h30;
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, d[3:0]};
        end else if (l >= 8'h61 && l <= 8'h66) begin
            d = l - 8'h57;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        logic [7:0] c;
        logic       eos;
        logic       err;
        logic [4:0] hv;
        c      = i_in.in_byte;
        eos    = i_in.end_of_string;
        err    = 1'b0;
        hv     = f_hex(c);
        acc    = '0;
        acc.cnt = r_cnt;
        n_bp   = r_bp;
        n_hp   = r_hp;
        n_hn   = r_hn;
        n_halt = r_halt;
        if (r_halt) begin
            if (eos) begin
                n_halt = 1'b0;
                n_bp   = 1'b0;
                n_hp   = HEX_NONE;
                n_hn   = 4'd0;
                acc.cnt = 16'd0;
            end
        end else begin
            if (r_cnt < r_max) begin
                if (r_bp) begin
                    n_bp = 1'b0;
                    if ((c | CASE_BIT) == CHR_X) begin
                        n_hp = HEX_FIRST;
                    end else if (c == CHR_BSLASH) begin
                        acc = f_emit(acc, CHR_BSLASH, r_max);
                    end else begin
                        acc = f_emit(acc, CHR_BSLASH, r_max);
                        acc = f_emit(acc, c, r_max);
                    end
                end else if (r_hp == HEX_FIRST) begin
                    if (!hv[4]) begin
                        err = 1'b1;
                        acc = f_put(acc, 8'd0, KIND_ERROR);
                        n_halt = !eos;
                        n_hp   = HEX_NONE;
                        if (eos) begin
                            n_hn    = 4'd0;
                            acc.cnt = 16'd0;
                        end
                    end else begin
                        n_hn = hv[3:0];
                        n_hp = HEX_HELD;
                    end
                end else if (r_hp == HEX_HELD) begin
                    n_hp = HEX_NONE;
                    if (hv[4]) begin
                        acc = f_emit(acc, {r_hn, hv[3:0]}, r_max);
                    end else begin
                        acc = f_emit(acc, {4'd0, r_hn}, r_max);
                        if (c == CHR_BSLASH) begin
                            n_bp = 1'b1;
                        end else begin
                            acc = f_emit(acc, c, r_max);
                        end
                    end
                end else begin
                    if (c == CHR_BSLASH) begin
                        n_bp = 1'b1;
                    end else begin
                        acc = f_emit(acc, c, r_max);
                    end
                end
            end
            if (eos && !err) begin
                if (n_bp) begin
                    acc = f_emit(acc, CHR_BSLASH, r_max);
                end
                if (n_hp == HEX_HELD) begin
                    acc = f_emit(acc, {4'd0, n_hn}, r_max);
                end
                acc = f_put(acc, 8'd0, KIND_END);
                acc.cnt = 16'd0;
                n_bp = 1'b0;
                n_hp = HEX_NONE;
                n_hn = 4'd0;
            end
        end
        n_cnt = acc.cnt;
        for (int i = 0; i < RES_PER_ITEM; i++) begin
            acc.b.res[i].run_last = (2'(i) == acc.b.n - 2'd1);
        end
    end

    assign o_bundle = acc.b;
    assign o_push   = accept && (acc.b.n != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp   <= 1'b0;
            r_hp   <= HEX_NONE;
            r_hn   <= 4'd0;
            r_cnt  <= 16'd0;
            r_halt <= 1'b0;
            r_max  <= MAX_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if (accept) begin
                r_bp   <= n_bp;
                r_hp   <= n_hp;
                r_hn   <= n_hn;
                r_cnt  <= n_cnt;
                r_halt <= n_halt;
            end
        end
    end

endmodule

// ===== sv/hee_fifo.sv =====
// Two-entry queue of result bundles between front and back.
module hee_fifo import hee_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_bundle o_data
);

    t_bundle    r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// ===== sv/hee_back.sv =====
// Back end: hands out the results of the head bundle one result per cycle while i_out_ready is high.
module hee_back import hee_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_bundle i_bundle,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out
);

    logic [1:0] r_idx;
    logic       take;
    logic       last;

    assign o_out_valid = !i_q_empty;
    assign o_out       = i_bundle.res[r_idx];
    assign take        = o_out_valid && i_out_ready;
    assign last        = (r_idx == i_bundle.n - 2'd1);
    assign o_pop       = take && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (take) begin
            r_idx <= last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

// ===== sv/hex_escape_unescaper.sv =====
// Top level of the backslash hex escape decoder.
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+--------------------------
//  config   | i_cfg_valid  | o_cfg_ready  | i_cfg_data (byte limit)
//  input    | i_in_valid   | o_in_ready   | i_in  (t_in)
//  output   | o_out_valid  | i_out_ready  | o_out (t_out)
//
// An item is decoded in the cycle it is accepted; its 0..3 results land in a
// two-entry bundle queue and leave one per cycle while i_out_ready is high, so
// items of one result each run at one item per cycle. Input stalls only when
// the queue is full. Reset is synchronous, active low, and restores the limit
// to 65535. Config is always ready.
module hex_escape_unescaper import hee_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out
);

    logic    q_full;
    logic    q_empty;
    logic    push;
    logic    pop;
    t_bundle front_bundle;
    t_bundle head_bundle;

    assign o_cfg_ready = 1'b1;

    hee_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_bundle    (front_bundle)
    );

    hee_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_bundle),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (head_bundle)
    );

    hee_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_bundle    (head_bundle),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
